@@ rtl/core/olid_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list package
// Field widths, operation codes and the per-cell update actions shared by
// the interfaces, the cell row and the top level.
// ----------------------------------------------------------------------------
package olid_pkg;

  localparam int OPCODE_W = 2;
  localparam int POS_W    = 7;
  localparam int VALUE_W  = 32;
  localparam int LEN_W    = 7;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOCATE = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_FROM_LEFT  = 2'd2,
    CELL_FROM_RIGHT = 2'd3
  } cell_action_t;

endpackage

@@ rtl/core/olid_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list channel interfaces
// Request and response channels with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface olid_req_if import olid_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [POS_W-1:0]    position;
  value_t              value;

  modport source (output valid, output opcode, output position, output value, input ready);
  modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

interface olid_rsp_if import olid_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             ok;
  value_t           removed_value;
  logic [POS_W-1:0] found_position;
  logic [LEN_W-1:0] list_length;

  modport source (output valid, output ok, output removed_value, output found_position,
                  output list_length, input ready);
  modport sink   (input valid, input ok, input removed_value, input found_position,
                  input list_length, output ready);
endinterface

@@ rtl/core/olid_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list cell
// Holds one list entry, takes a new value or a neighbour's entry when the
// list shifts, and compares its entry with the search key.
// ----------------------------------------------------------------------------
module olid_cell import olid_pkg::*; (
  input  logic         clk,
  input  cell_action_t action,
  input  value_t       new_value,
  input  value_t       left_value,
  input  value_t       right_value,
  input  value_t       key,
  input  logic         occupied,
  output value_t       entry,
  output logic         match
);

  always_ff @(posedge clk) begin
    unique case (action)
      CELL_HOLD:       entry <= entry;
      CELL_LOAD:       entry <= new_value;
      CELL_FROM_LEFT:  entry <= left_value;
      CELL_FROM_RIGHT: entry <= right_value;
      default:         entry <= entry;
    endcase
  end

  assign match = occupied && (entry == key);

endmodule

@@ rtl/core/olid_first_hit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list first-hit encoder
// Isolates the lowest set bit of the match vector and encodes its index.
// ----------------------------------------------------------------------------
module olid_first_hit #(
  parameter int N = 64
) (
  input  logic [N-1:0]         hits,
  output logic                 any,
  output logic [$clog2(N)-1:0] index
);

  localparam int IDX_W = $clog2(N);

  logic [N-1:0] lowest;

  assign lowest = hits & (~hits + N'(1));
  assign any    = |hits;

  always_comb begin
    index = '0;
    for (int k = 0; k < N; k++) begin
      if (lowest[k]) begin
        index = index | IDX_W'(k);
      end
    end
  end

endmodule

@@ rtl/core/ordered_list_insert_delete_locate.sv @@
`timescale 1ns / 1ps
// A request is registered in the first pipeline stage on acceptance, its result in the
// output stage. One transaction per cycle while the response channel does not stall;
// the cell row shifts and compares every entry in the acceptance cycle, and the
// first-hit encoder reads the first stage. Reset clears the list length and both
// pipeline stages; entries are not cleared and hold nothing readable until written.
// ----------------------------------------------------------------------------
// Ordered list with insert, delete and locate
// A row of cells holds the list; each transaction inserts, deletes or
// searches and returns one response.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_locate import olid_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic      clk,
  input  logic      rst,
  olid_req_if.sink  req,
  olid_rsp_if.source rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CMP_W-1:0] pos_w;
  logic [CMP_W-1:0] cnt_w;
  logic [CMP_W-1:0] slot;
  logic             fire;
  logic             ins_ok;
  logic             del_ok;

  value_t              entry [CAPACITY];
  cell_action_t        action [CAPACITY];
  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] pick;
  value_t              removed;

  logic                s1_valid;
  logic                s1_locate;
  logic                s1_ok;
  value_t              s1_removed;
  logic [CAPACITY-1:0] s1_match;
  logic [CNT_W-1:0]    s1_len;
  logic                s1_adv;

  logic                hit;
  logic [IDX_W-1:0]    hit_index;
  logic [CNT_W-1:0]    found_full;

  logic             out_valid;
  logic             out_ok;
  value_t           out_removed;
  logic [POS_W-1:0] out_found;
  logic [LEN_W-1:0] out_len;

  assign pos_w  = CMP_W'(req.position);
  assign cnt_w  = CMP_W'(count);
  assign slot   = pos_w - CMP_W'(1);
  assign fire   = req.valid && req.ready;
  assign ins_ok = (req.opcode == OP_INSERT) && (pos_w != '0) &&
                  (pos_w <= cnt_w + CMP_W'(1)) && (cnt_w < CMP_W'(CAPACITY));
  assign del_ok = (req.opcode == OP_DELETE) && (pos_w != '0) && (pos_w <= cnt_w);

  assign s1_adv    = !out_valid || rsp.ready;
  assign req.ready = !rst && (!s1_valid || s1_adv);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CMP_W-1:0] IDX = CMP_W'(i);
    value_t left_value;
    value_t right_value;

    if (i == 0) begin : g_first
      assign left_value = entry[i];
    end else begin : g_mid_l
      assign left_value = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_value = entry[i];
    end else begin : g_mid_r
      assign right_value = entry[i+1];
    end

    assign pick[i] = (IDX == slot);

    always_comb begin
      action[i] = CELL_HOLD;
      if (fire && ins_ok) begin
        if (IDX == slot) begin
          action[i] = CELL_LOAD;
        end else if (IDX > slot) begin
          action[i] = CELL_FROM_LEFT;
        end
      end else if (fire && del_ok && (IDX >= slot)) begin
        action[i] = CELL_FROM_RIGHT;
      end
    end

    olid_cell u_cell (
      .clk         (clk),
      .action      (action[i]),
      .new_value   (req.value),
      .left_value  (left_value),
      .right_value (right_value),
      .key         (req.value),
      .occupied    (IDX < cnt_w),
      .entry       (entry[i]),
      .match       (match[i])
    );
  end

  always_comb begin
    removed = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (pick[k]) begin
        removed = removed | entry[k];
      end
    end
  end

  always_comb begin
    count_next = count;
    if (fire && ins_ok) begin
      count_next = count + CNT_W'(1);
    end else if (fire && del_ok) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      s1_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (fire) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_locate  <= (req.opcode == OP_LOCATE);
      s1_ok      <= ins_ok || del_ok;
      s1_removed <= del_ok ? removed : '0;
      s1_match   <= match;
      s1_len     <= count_next;
    end
  end

  olid_first_hit #(.N(CAPACITY)) u_first_hit (
    .hits  (s1_match),
    .any   (hit),
    .index (hit_index)
  );

  assign found_full = CNT_W'(hit_index) + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_adv) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      out_ok      <= s1_locate ? hit : s1_ok;
      out_removed <= s1_removed;
      out_found   <= (s1_locate && hit) ? POS_W'(found_full) : '0;
      out_len     <= LEN_W'(s1_len);
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.ok             = out_ok;
  assign rsp.removed_value  = out_removed;
  assign rsp.found_position = out_found;
  assign rsp.list_length    = out_len;

`ifndef SYNTHESIS
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (fire && ins_ok) |=> (count == $past(count) + CNT_W'(1)))
    else $error("Length did not grow after a successful insert.");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (rst)
    (fire && del_ok) |=> (count == $past(count) - CNT_W'(1)))
    else $error("Length did not shrink after a successful delete.");

  a_other_keeps: assert property (@(posedge clk) disable iff (rst)
    (!(fire && (ins_ok || del_ok))) |=> (count == $past(count)))
    else $error("Length changed without a successful insert or delete.");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("Length exceeds the list capacity.");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.found_position != '0)) |-> rsp.ok)
    else $error("A found position was reported without success.");
`endif

endmodule
